// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies prop in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Check that cond implies prop in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// File: src/srfp_pkg.sv
package srfp_pkg;

    localparam int MAX_FRAME_BYTES = 32;
    localparam int POS_W = 6;
    localparam int PAYLOAD_DEPTH = 22;
    localparam int PAYLOAD_FIRST = 3;
    localparam logic [16:0] TEMP_OFFSET = 17'd500;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_MISMATCH,
        STATUS_TOO_LONG
    } status_t;

    typedef logic [PAYLOAD_DEPTH-1:0][7:0] payload_t;

    typedef struct packed {
        logic    fire;
        status_t status;
    } emit_t;

endpackage

// File: src/srfp_in_stage.sv
module srfp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       frame_start,
    input  logic       advance,
    output logic       item_valid,
    output logic [7:0] item_byte,
    output logic       item_start
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       accept;

    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the payload of a waiting transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= rx_byte;
            start_reg <= frame_start;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_start = start_reg;

endmodule

// File: src/srfp_frame_core.sv
module srfp_frame_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [7:0]        item_byte,
    input  logic              item_start,
    input  logic              advance,
    output srfp_pkg::emit_t   emit,
    output srfp_pkg::payload_t payload
);

    logic [srfp_pkg::POS_W-1:0] pos_reg;
    logic [srfp_pkg::POS_W-1:0] pos_next;
    logic [7:0]                 len_reg;
    logic [7:0]                 len_next;
    logic [7:0]                 sum_reg;
    logic [7:0]                 sum_next;
    logic                       active_reg;
    logic                       active_next;
    srfp_pkg::payload_t         payload_reg;
    srfp_pkg::payload_t         payload_next;
    logic [7:0]                 sum_add;
    logic [7:0]                 expect_sum;
    logic                       too_long;
    logic                       at_check;

    assign sum_add    = sum_reg + item_byte;
    assign expect_sum = (~sum_reg) + 8'd1;
    assign too_long   = ({1'b0, item_byte} + 9'd2) >= 9'(srfp_pkg::MAX_FRAME_BYTES);
    assign at_check   = {3'b000, pos_reg} >= ({1'b0, len_reg} + 9'd2);

    always_comb
    begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        sum_next     = sum_reg;
        active_next  = active_reg;
        payload_next = payload_reg;
        emit.fire    = 1'b0;
        emit.status  = srfp_pkg::STATUS_OK;
        if (item_valid)
        begin
            if (item_start)
            begin
                payload_next = '0;
                len_next     = 8'd0;
                sum_next     = item_byte;
                pos_next     = srfp_pkg::POS_W'(1);
                active_next  = 1'b1;
            end
            else if (active_reg)
            begin
                if (pos_reg == srfp_pkg::POS_W'(1))
                begin
                    len_next = item_byte;
                    if (too_long)
                    begin
                        active_next = 1'b0;
                        pos_next    = '0;
                        emit.fire   = 1'b1;
                        emit.status = srfp_pkg::STATUS_TOO_LONG;
                    end
                    else
                    begin
                        sum_next = sum_add;
                        pos_next = srfp_pkg::POS_W'(2);
                    end
                end
                else if (at_check)
                begin
                    active_next = 1'b0;
                    pos_next    = '0;
                    emit.fire   = 1'b1;
                    emit.status = (expect_sum == item_byte) ? srfp_pkg::STATUS_OK
                                                            : srfp_pkg::STATUS_MISMATCH;
                end
                else
                begin
                    for (int i = 0; i < srfp_pkg::PAYLOAD_DEPTH; i++)
                    begin
                        if (pos_reg == srfp_pkg::POS_W'(srfp_pkg::PAYLOAD_FIRST + i))
                        begin
                            payload_next[i] = item_byte;
                        end
                    end
                    sum_next = sum_add;
                    pos_next = pos_reg + srfp_pkg::POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            len_reg     <= 8'd0;
            sum_reg     <= 8'd0;
            active_reg  <= 1'b0;
            payload_reg <= '0;
        end
        else if (advance)
        begin
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            sum_reg     <= sum_next;
            active_reg  <= active_next;
            payload_reg <= payload_next;
        end
    end

    assign payload = payload_reg;

endmodule

// File: src/srfp_out_stage.sv
module srfp_out_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  srfp_pkg::status_t         load_status,
    input  srfp_pkg::payload_t        payload,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic [15:0]               tvoc_ppb,
    output logic [15:0]               no2_ppb,
    output logic [15:0]               pm1_level,
    output logic [15:0]               pm25_level,
    output logic [15:0]               pm10_level,
    output logic [15:0]               hcho_ppb,
    output logic signed [16:0]        temperature_tenths,
    output logic [15:0]               humidity_tenths,
    output logic [7:0]                fault_primary,
    output logic [7:0]                fault_secondary,
    output logic                      fault_any
);

    logic        valid_reg;
    logic        valid_next;
    logic [1:0]  status_reg;
    logic [15:0] tvoc_reg;
    logic [15:0] no2_reg;
    logic [15:0] pm1_reg;
    logic [15:0] pm25_reg;
    logic [15:0] pm10_reg;
    logic [15:0] hcho_reg;
    logic [16:0] temp_reg;
    logic [15:0] hum_reg;
    logic [7:0]  fault1_reg;
    logic [7:0]  fault2_reg;
    logic        fault_any_reg;
    logic        good;
    logic [15:0] temp_word;

    assign good      = (load_status == srfp_pkg::STATUS_OK);
    assign temp_word = {payload[10], payload[11]};

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // zero every reading of a failed frame
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg    <= load_status;
            tvoc_reg      <= good ? {payload[0], payload[1]} : 16'd0;
            no2_reg       <= good ? {payload[2], payload[3]} : 16'd0;
            pm1_reg       <= good ? {payload[4], payload[5]} : 16'd0;
            pm25_reg      <= good ? {payload[6], payload[7]} : 16'd0;
            pm10_reg      <= good ? {payload[8], payload[9]} : 16'd0;
            hcho_reg      <= good ? {payload[18], payload[19]} : 16'd0;
            temp_reg      <= good ? ({temp_word[15], temp_word} - srfp_pkg::TEMP_OFFSET)
                                  : 17'd0;
            hum_reg       <= good ? {payload[12], payload[13]} : 16'd0;
            fault1_reg    <= good ? payload[20] : 8'd0;
            fault2_reg    <= good ? payload[21] : 8'd0;
            fault_any_reg <= good && ((payload[20] != 8'd0) || (payload[21] != 8'd0));
        end
    end

    assign out_valid          = valid_reg;
    assign status             = status_reg;
    assign tvoc_ppb           = tvoc_reg;
    assign no2_ppb            = no2_reg;
    assign pm1_level          = pm1_reg;
    assign pm25_level         = pm25_reg;
    assign pm10_level         = pm10_reg;
    assign hcho_ppb           = hcho_reg;
    assign temperature_tenths = signed'(temp_reg);
    assign humidity_tenths    = hum_reg;
    assign fault_primary      = fault1_reg;
    assign fault_secondary    = fault2_reg;
    assign fault_any          = fault_any_reg;

endmodule

// File: src/sensor_response_frame_parser.sv
// Channel | Handshake           | Payload
// input   | in_valid, in_stall  | rx_byte, frame_start
// output  | out_valid, out_stall| status and decoded readings
//
// One byte per cycle while no frame-ending byte waits on a stalled result.
// Each byte passes an input register, then updates the frame tracker; results are registered.
// Reset clears the frame state and both valid flags; no clearing pass.
// A byte that ends a frame waits in the input register while a result is stalled;
// bytes that give no result keep flowing past a stalled result.
module sensor_response_frame_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [15:0]        tvoc_ppb,
    output logic [15:0]        no2_ppb,
    output logic [15:0]        pm1_level,
    output logic [15:0]        pm25_level,
    output logic [15:0]        pm10_level,
    output logic [15:0]        hcho_ppb,
    output logic signed [16:0] temperature_tenths,
    output logic [15:0]        humidity_tenths,
    output logic [7:0]         fault_primary,
    output logic [7:0]         fault_secondary,
    output logic               fault_any
);

    logic               item_valid;
    logic [7:0]         item_byte;
    logic               item_start;
    logic               advance;
    srfp_pkg::emit_t    emit;
    srfp_pkg::payload_t payload;

    // advance unless a result would land on a stalled one
    assign advance = item_valid && (!emit.fire || !out_valid || !out_stall);

    srfp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .frame_start(frame_start),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_start (item_start)
    );

    srfp_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_byte (item_byte),
        .item_start(item_start),
        .advance   (advance),
        .emit      (emit),
        .payload   (payload)
    );

    srfp_out_stage u_out (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (advance && emit.fire),
        .load_status       (emit.status),
        .payload           (payload),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .tvoc_ppb          (tvoc_ppb),
        .no2_ppb           (no2_ppb),
        .pm1_level         (pm1_level),
        .pm25_level        (pm25_level),
        .pm10_level        (pm10_level),
        .hcho_ppb          (hcho_ppb),
        .temperature_tenths(temperature_tenths),
        .humidity_tenths   (humidity_tenths),
        .fault_primary     (fault_primary),
        .fault_secondary   (fault_secondary),
        .fault_any         (fault_any)
    );

endmodule

// File: src/srfp_checker.sv
`include "assert_macros.svh"

module srfp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [7:0]         rx_byte,
    input logic               frame_start,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic [15:0]        tvoc_ppb,
    input logic [15:0]        no2_ppb,
    input logic [15:0]        pm1_level,
    input logic [15:0]        pm25_level,
    input logic [15:0]        pm10_level,
    input logic [15:0]        hcho_ppb,
    input logic signed [16:0] temperature_tenths,
    input logic [15:0]        humidity_tenths,
    input logic [7:0]         fault_primary,
    input logic [7:0]         fault_secondary,
    input logic               fault_any
);

    logic       failed;
    logic       readings_zero;
    logic       fault_seen;
    logic [8:0] in_word;

    assign failed = (status != srfp_pkg::STATUS_OK);
    assign readings_zero = (tvoc_ppb == 16'd0) && (no2_ppb == 16'd0) && (pm1_level == 16'd0)
        && (pm25_level == 16'd0) && (pm10_level == 16'd0) && (hcho_ppb == 16'd0)
        && (temperature_tenths == 17'sd0) && (humidity_tenths == 16'd0)
        && (fault_primary == 8'd0) && (fault_secondary == 8'd0) && !fault_any;
    assign fault_seen = (fault_primary != 8'd0) || (fault_secondary != 8'd0);
    assign in_word = {rx_byte, frame_start};

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status))
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_word))
    `ASSERT_IMPLIES(a_fail_zero, clk, rst_n, out_valid && failed, readings_zero)
    `ASSERT_IMPLIES(a_fault_any, clk, rst_n, out_valid, fault_any == fault_seen)
    `ASSERT_IMPLIES(a_status_code, clk, rst_n, out_valid, status != 2'd3)

endmodule

bind sensor_response_frame_parser srfp_checker u_srfp_checker (.*);
